FILE: hdl/text_mode_cell_renderer_top_assert.svh
// Assertion macros for the text-mode cell renderer.
// Included by the top level; no other dependencies.
`ifndef TEXT_MODE_CELL_RENDERER_TOP_ASSERT_SVH
`define TEXT_MODE_CELL_RENDERER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define TMCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define TMCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TMCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TMCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/tmcr_pkg.sv
// Package for the text-mode cell renderer: codes, constants, shared structs.
// No dependencies.
`default_nettype none

package tmcr_pkg;

    // Fixed glyph geometry
    localparam int GLYPH_HEIGHT = 8;
    localparam int REV_BIT      = 7;

    // Register reset values
    localparam logic [15:0] FG_RESET     = 16'h07e4;
    localparam logic [15:0] BG_RESET     = 16'h0000;
    localparam logic [7:0]  TOP_RESET    = 8'd20;
    localparam logic [7:0]  ACTIVE_RESET = 8'd200;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_CHAR_WR = 2'd0,
        ACT_FONT_WR = 2'd1,
        ACT_RENDER  = 2'd2,
        ACT_NONE    = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        REG_FG     = 2'd0,
        REG_BG     = 2'd1,
        REG_TOP    = 2'd2,
        REG_ACTIVE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] fg_colour;
        logic [15:0] bg_colour;
        logic [7:0]  top_offset;
        logic [7:0]  active_lines;
    } cfg_t;

    // Classified request, as queued for the back end
    typedef struct packed {
        act_t        action;
        logic [9:0]  address;
        logic [7:0]  wdata;
        logic        blank;
        logic [4:0]  row;
        logic [2:0]  grow;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

`default_nettype wire

FILE: hdl/tmcr_if.sv
// Channel interfaces for the text-mode cell renderer: request and result.
// No dependencies.
`default_nettype none

interface tmcr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [9:0] address;
    logic [7:0] write_data;
    logic [7:0] line;

    modport source (output valid, action, address, write_data, line, input ready);
    modport sink   (input valid, action, address, write_data, line, output ready);
endinterface

interface tmcr_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_0;
    logic [15:0] pixel_1;
    logic [15:0] pixel_2;
    logic [15:0] pixel_3;
    logic [15:0] pixel_4;
    logic [15:0] pixel_5;
    logic [15:0] pixel_6;
    logic [15:0] pixel_7;
    logic [5:0]  column;
    logic        last_cell;

    modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                    pixel_6, pixel_7, column, last_cell, input ready);
    modport sink   (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                    pixel_6, pixel_7, column, last_cell, output ready);
endinterface

`default_nettype wire

FILE: hdl/tmcr_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on tmcr_pkg.
`default_nettype none

module tmcr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  tmcr_pkg::cmd_t     push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               pop_valid,
    output tmcr_pkg::cmd_t     pop_cmd
);

    localparam int PTR_W = $clog2(tmcr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tmcr_pkg::QUEUE_DEPTH + 1);

    tmcr_pkg::cmd_t   slot_reg [tmcr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(tmcr_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(tmcr_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(tmcr_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

FILE: hdl/tmcr_front.sv
// Front end: takes requests, works out window position and glyph row.
// Depends on tmcr_pkg and tmcr_if.
`default_nettype none

module tmcr_front #(
    parameter int TEXT_ROWS = 25
) (
    tmcr_req_if.sink               request,
    input  tmcr_pkg::cfg_t         cfg,
    input  tmcr_pkg::back_stat_t   stat,
    input  wire logic              q_full,
    output logic                   push,
    output tmcr_pkg::cmd_t         cmd
);

    localparam int WIN_H = TEXT_ROWS * tmcr_pkg::GLYPH_HEIGHT;

    logic       above;
    logic [7:0] y;
    logic       past_end;

    // No requests during the clearing pass or with a full queue
    assign request.ready = !q_full && !stat.clearing;

    // Drop unused action codes at the door
    assign push = request.valid && request.ready &&
                  (tmcr_pkg::act_t'(request.action) != tmcr_pkg::ACT_NONE);

    // Window test
    assign above    = (request.line < cfg.top_offset);
    assign y        = request.line - cfg.top_offset;
    assign past_end = (y >= cfg.active_lines) || ({1'b0, y} >= 9'(WIN_H));

    always_comb
    begin
        cmd.action  = tmcr_pkg::act_t'(request.action);
        cmd.address = request.address;
        cmd.wdata   = request.write_data;
        cmd.blank   = above || past_end;
        cmd.row     = y[7:3];
        cmd.grow    = y[2:0];
    end

endmodule

`default_nettype wire

FILE: hdl/tmcr_back.sv
// Back end: store writes, clearing pass, and the per-cell render pipeline.
// Depends on tmcr_pkg and tmcr_if.
`default_nettype none

module tmcr_back #(
    parameter int TEXT_COLUMNS = 40,
    parameter int STORE_DEPTH  = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  tmcr_pkg::cfg_t         cfg,
    input  wire logic              q_valid,
    input  tmcr_pkg::cmd_t         q_cmd,
    output logic                   q_pop,
    tmcr_res_if.source             result,
    output tmcr_pkg::back_stat_t   stat
);

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_RENDER = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic [5:0]       col_reg;
    logic [AW-1:0]    cell_reg;
    logic             blank_reg;
    logic [2:0]       grow_reg;

    // Stage 1: character byte
    logic             v1_reg;
    logic [5:0]       col1_reg;
    logic             last1_reg;
    logic             blank1_reg;
    logic [7:0]       char_q_reg;
    // Stage 2: glyph byte
    logic             v2_reg;
    logic [5:0]       col2_reg;
    logic             last2_reg;
    logic             blank2_reg;
    logic             rev2_reg;
    logic [7:0]       font_q_reg;
    // Stage 3: output register
    logic             v3_reg;
    logic [5:0]       col3_reg;
    logic             last3_reg;
    logic [15:0]      pix_reg [8];

    logic [7:0]       char_mem [STORE_DEPTH];
    logic [7:0]       font_mem [STORE_DEPTH];

    logic             advance;
    logic             pipe_empty;
    logic             start;
    logic             issue;
    logic             col_last;
    logic             clr_we;
    logic             char_wr;
    logic             font_wr;
    logic             char_re;
    logic             font_re;
    logic [11:0]      base_full;
    logic [11:0]      base_wrap;
    logic [AW-1:0]    faddr;
    logic [7:0]       bits2;

    // Handshake and sequencing
    assign advance    = !v3_reg || result.ready;
    assign pipe_empty = !v1_reg && !v2_reg;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid && pipe_empty;
    assign start      = q_pop && (q_cmd.action == tmcr_pkg::ACT_RENDER);
    assign char_wr    = q_pop && (q_cmd.action == tmcr_pkg::ACT_CHAR_WR);
    assign font_wr    = q_pop && (q_cmd.action == tmcr_pkg::ACT_FONT_WR);
    assign issue      = (state_reg == ST_RENDER) && advance;
    assign col_last   = (col_reg == 6'(TEXT_COLUMNS - 1));
    assign clr_we     = (state_reg == ST_CLEAR);
    assign char_re    = issue && !blank_reg;
    assign font_re    = advance && v1_reg && !blank1_reg;
    assign faddr      = AW'({char_q_reg[6:0], grow_reg});

    assign stat.clearing = (state_reg == ST_CLEAR);

    // First cell address of the text row, wrapped into the store
    assign base_full = 12'(q_cmd.row) * 12'(TEXT_COLUMNS);
    assign base_wrap = (base_full >= 12'(STORE_DEPTH)) ?
                       base_full - 12'(STORE_DEPTH) : base_full;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(STORE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_RENDER;
            end
            ST_RENDER:
            begin
                if (issue && col_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_we)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (advance)
            begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    // Column walk
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            col_reg   <= '0;
            cell_reg  <= AW'(base_wrap);
            blank_reg <= q_cmd.blank;
            grow_reg  <= q_cmd.grow;
        end
        else if (issue)
        begin
            col_reg  <= col_reg + 1'b1;
            cell_reg <= (cell_reg == AW'(STORE_DEPTH - 1)) ? '0 : cell_reg + 1'b1;
        end
    end

    // Character store: clearing pass, writes, one read per cell
    always_ff @(posedge clk)
    begin
        if (clr_we)
            char_mem[clr_cnt_reg] <= '0;
        else if (char_wr)
            char_mem[AW'(q_cmd.address)] <= q_cmd.wdata;
        if (char_re)
            char_q_reg <= char_mem[cell_reg];
    end

    // Font store
    always_ff @(posedge clk)
    begin
        if (font_wr)
            font_mem[AW'(q_cmd.address)] <= q_cmd.wdata;
        if (font_re)
            font_q_reg <= font_mem[faddr];
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col1_reg   <= col_reg;
            last1_reg  <= col_last;
            blank1_reg <= blank_reg;
            col2_reg   <= col1_reg;
            last2_reg  <= last1_reg;
            blank2_reg <= blank1_reg;
            rev2_reg   <= char_q_reg[tmcr_pkg::REV_BIT];
            col3_reg   <= col2_reg;
            last3_reg  <= last2_reg;
            for (int k = 0; k < 8; k++)
                pix_reg[k] <= bits2[7-k] ? cfg.fg_colour : cfg.bg_colour;
        end
    end

    // Glyph bits, reverse video and blank lines
    assign bits2 = blank2_reg ? 8'h00 : (font_q_reg ^ {8{rev2_reg}});

    assign result.valid     = v3_reg;
    assign result.pixel_0   = pix_reg[0];
    assign result.pixel_1   = pix_reg[1];
    assign result.pixel_2   = pix_reg[2];
    assign result.pixel_3   = pix_reg[3];
    assign result.pixel_4   = pix_reg[4];
    assign result.pixel_5   = pix_reg[5];
    assign result.pixel_6   = pix_reg[6];
    assign result.pixel_7   = pix_reg[7];
    assign result.column    = col3_reg;
    assign result.last_cell = last3_reg;

endmodule

`default_nettype wire

FILE: hdl/text_mode_cell_renderer_top.sv
// Channel    | Dir | Payload                                   | Per request
// request    | in  | action, address, write_data, line         | one
// result     | out | pixel_0..pixel_7, column, last_cell       | TEXT_COLUMNS per render
// cfg        | in  | cfg_we, cfg_index, cfg_data               | register write
//
// A render request produces TEXT_COLUMNS cells, one per cycle while the result is not
// stalled; the next command is taken once the character and glyph stages hold no cell.
// A store write is done when the back end takes it from the queue. After reset the
// character store is swept to zero, and no request is taken until it is done.
// A stalled result holds the cell pipeline; the two-entry queue fills with requests.
//
// Top level of the text-mode cell renderer.
// Depends on tmcr_pkg, tmcr_if, tmcr_front, tmcr_queue, tmcr_back.
`default_nettype none

`include "text_mode_cell_renderer_top_assert.svh"

module text_mode_cell_renderer_top #(
    parameter int TEXT_COLUMNS = 40,
    parameter int TEXT_ROWS    = 25,
    parameter int STORE_DEPTH  = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tmcr_req_if.sink         request,
    tmcr_res_if.source       result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    tmcr_pkg::cfg_t        cfg_reg;
    tmcr_pkg::back_stat_t  stat;
    tmcr_pkg::cmd_t        push_cmd;
    tmcr_pkg::cmd_t        pop_cmd;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_colour    <= tmcr_pkg::FG_RESET;
            cfg_reg.bg_colour    <= tmcr_pkg::BG_RESET;
            cfg_reg.top_offset   <= tmcr_pkg::TOP_RESET;
            cfg_reg.active_lines <= tmcr_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            case (tmcr_pkg::reg_idx_t'(cfg_index))
                tmcr_pkg::REG_FG:     cfg_reg.fg_colour    <= cfg_data;
                tmcr_pkg::REG_BG:     cfg_reg.bg_colour    <= cfg_data;
                tmcr_pkg::REG_TOP:    cfg_reg.top_offset   <= cfg_data[7:0];
                tmcr_pkg::REG_ACTIVE: cfg_reg.active_lines <= cfg_data[7:0];
                default:              cfg_reg              <= cfg_reg;
            endcase
        end
    end

    tmcr_front #(
        .TEXT_ROWS (TEXT_ROWS)
    ) u_front (
        .request (request),
        .cfg     (cfg_reg),
        .stat    (stat),
        .q_full  (q_full),
        .push    (q_push),
        .cmd     (push_cmd)
    );

    tmcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    tmcr_back #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .STORE_DEPTH  (STORE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .result  (result),
        .stat    (stat)
    );

    // Checks
    `TMCR_ASSERT_IMPLY(a_no_req_clearing, clk, rst_n, stat.clearing, !request.ready)
    `TMCR_ASSERT_IMPLY(a_no_push_full, clk, rst_n, q_push, !q_full)
    `TMCR_ASSERT_IMPLY(a_no_result_clearing, clk, rst_n, stat.clearing, !result.valid)
    `TMCR_ASSERT_IMPLY(a_last_col, clk, rst_n, result.valid && result.last_cell, result.column == 6'(TEXT_COLUMNS - 1))
    `TMCR_ASSERT_NEXT(a_pop_frees, clk, rst_n, q_pop && !q_push, !q_full)

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_mode_cell_renderer_top: directed table, then random traffic.
// Depends on tmcr_pkg, the tmcr_req_if/tmcr_res_if channels and the renderer RTL.

module testbench;
    import tmcr_pkg::*;

    localparam int TEXT_COLUMNS = 40;
    localparam int TEXT_ROWS    = 25;
    localparam int STORE_DEPTH  = 1024;
    localparam int PERIOD       = 12;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 6;
    localparam int PER_PHASE    = 66;

    typedef struct {
        act_t       action;
        logic [9:0] address;
        logic [7:0] write_data;
        logic [7:0] line;
    } request_t;

    // One directed row; "typed" rows carry a uniform pixel value for every cell
    typedef struct {
        request_t    req;
        bit          typed;
        logic [15:0] pixel;
    } script_row_t;

    typedef struct packed {
        logic [7:0][15:0] pixels;
        logic [5:0]       column;
        logic             last_cell;
    } cell_t;

    logic clk = 1'b0;
    logic rst_n;
    logic        cfg_we;
    reg_idx_t    cfg_index;
    logic [15:0] cfg_data;

    tmcr_req_if req();
    tmcr_res_if res();

    text_mode_cell_renderer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    // Shadow copy of the block state
    cfg_t       shadow_cfg;
    logic [7:0] char_mem [STORE_DEPTH];
    logic [7:0] font_mem [STORE_DEPTH];
    bit         font_loaded [STORE_DEPTH];

    cell_t pending_cells [$];
    int    mismatches = 0;
    int    cycles = 0;
    int    send_idle_pct = 0;
    int    res_stall_pct = 0;
    int    hold_asked = 0;

    script_row_t script [19] = '{
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd0},   1'b1, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd19},  1'b1, 16'h0000},
        '{'{ACT_NONE,    10'h3ff,  8'hff, 8'hff},  1'b0, 16'h0000},
        '{'{ACT_FONT_WR, 10'd0,    8'hff, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd20},  1'b1, 16'h07e4},
        '{'{ACT_FONT_WR, 10'd1,    8'h00, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd21},  1'b1, 16'h0000},
        '{'{ACT_CHAR_WR, 10'd0,    8'h80, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd20},  1'b0, 16'h0000},
        '{'{ACT_FONT_WR, 10'h3ff,  8'haa, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_FONT_WR, 10'd7,    8'h5a, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_CHAR_WR, 10'd41,   8'h7f, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd35},  1'b0, 16'h0000},
        '{'{ACT_CHAR_WR, 10'h3ff,  8'hff, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_CHAR_WR, 10'd999,  8'h00, 8'd0},   1'b0, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd219}, 1'b0, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd220}, 1'b1, 16'h0000},
        '{'{ACT_RENDER,  10'd0,    8'h00, 8'd239}, 1'b1, 16'h0000},
        '{'{ACT_NONE,    10'd0,    8'h00, 8'd0},   1'b0, 16'h0000}
    };

    // Window position of a display line; returns 1 for a blank line
    function automatic bit line_blank(input logic [7:0] line, output int row, output int grow);
        int y;
        row  = 0;
        grow = 0;
        if (line < shadow_cfg.top_offset)
            return 1'b1;
        y    = int'(line) - int'(shadow_cfg.top_offset);
        row  = y / GLYPH_HEIGHT;
        grow = y % GLYPH_HEIGHT;
        return (y >= int'(shadow_cfg.active_lines)) || (y >= TEXT_ROWS * GLYPH_HEIGHT);
    endfunction

    function automatic int glyph_addr(input int col, input int row, input int grow);
        logic [7:0] code;
        code = char_mem[(col + row * TEXT_COLUMNS) % STORE_DEPTH];
        return (int'(code[6:0]) * GLYPH_HEIGHT + grow) % STORE_DEPTH;
    endfunction

    // Update the shadow state and queue the cells a request should produce
    task automatic track_request(input request_t it);
        bit         blank;
        int         row;
        int         grow;
        logic [7:0] code;
        logic [7:0] bits;
        cell_t      c;
        case (it.action)
            ACT_CHAR_WR: char_mem[it.address] = it.write_data;
            ACT_FONT_WR:
            begin
                font_mem[it.address]    = it.write_data;
                font_loaded[it.address] = 1'b1;
            end
            ACT_RENDER:
            begin
                blank = line_blank(it.line, row, grow);
                for (int col = 0; col < TEXT_COLUMNS; col++)
                begin
                    bits = 8'h00;
                    if (!blank)
                    begin
                        code = char_mem[(col + row * TEXT_COLUMNS) % STORE_DEPTH];
                        bits = font_mem[glyph_addr(col, row, grow)];
                        if (code[REV_BIT])
                            bits = ~bits;
                    end
                    for (int b = 0; b < 8; b++)
                        c.pixels[b] = bits[7 - b] ? shadow_cfg.fg_colour : shadow_cfg.bg_colour;
                    c.column    = 6'(col);
                    c.last_cell = (col == TEXT_COLUMNS - 1);
                    pending_cells.push_back(c);
                end
            end
            default: ;
        endcase
    endtask

    // Offer one request, with random idle cycles first, and wait for the handshake
    task automatic send_request(input request_t it, input bit typed = 1'b0,
                                input logic [15:0] pixel = 16'h0000);
        cell_t c;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.action     <= it.action;
        req.address    <= it.address;
        req.write_data <= it.write_data;
        req.line       <= it.line;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (typed)
        begin
            for (int col = 0; col < TEXT_COLUMNS; col++)
            begin
                c.pixels    = {8{pixel}};
                c.column    = 6'(col);
                c.last_cell = (col == TEXT_COLUMNS - 1);
                pending_cells.push_back(c);
            end
        end
        else
            track_request(it);
    endtask

    // Stop offering and wait until every expected cell has come out
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_registers(input logic [15:0] fg, input logic [15:0] bg,
                                   input logic [7:0] top, input logic [7:0] active);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FG;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= REG_BG;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_index <= REG_TOP;
        cfg_data  <= {8'h00, top};
        @(posedge clk);
        cfg_index <= REG_ACTIVE;
        cfg_data  <= {8'h00, active};
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cfg = '{fg_colour: fg, bg_colour: bg, top_offset: top, active_lines: active};
    endtask

    // Random render line, biased into the text window, with missing glyph rows loaded first
    task automatic random_render();
        request_t it;
        int       row;
        int       grow;
        int       fa;
        int       y;
        it.action     = ACT_RENDER;
        it.address    = 10'($urandom_range(0, 1023));
        it.write_data = 8'($urandom_range(0, 255));
        y = int'(shadow_cfg.top_offset) + $urandom_range(0, 199);
        if ($urandom_range(0, 3) == 0 || y > 239)
            y = $urandom_range(0, 239);
        it.line = 8'(y);
        if (!line_blank(it.line, row, grow))
        begin
            for (int col = 0; col < TEXT_COLUMNS; col++)
            begin
                fa = glyph_addr(col, row, grow);
                if (!font_loaded[fa])
                    send_request('{ACT_FONT_WR, 10'(fa), 8'($urandom_range(0, 255)), 8'h00});
            end
        end
        send_request(it);
    endtask

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d cells still expected", $time, pending_cells.size());
            $display("text_mode_cell_renderer_top regression: fail");
            $finish;
        end
    end

    // Result side: check accepted cells, then drive ready for the next edge
    initial
    begin
        cell_t got;
        cell_t want;
        int    hold_served;
        int    hold_left;
        hold_served = 0;
        hold_left   = 0;
        res.ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
            begin
                got.pixels = {res.pixel_7, res.pixel_6, res.pixel_5, res.pixel_4,
                              res.pixel_3, res.pixel_2, res.pixel_1, res.pixel_0};
                got.column    = res.column;
                got.last_cell = res.last_cell;
                if (pending_cells.size() == 0)
                begin
                    $display("%0t: unexpected cell, expected none, got column %0d",
                             $time, got.column);
                    mismatches++;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    for (int b = 0; b < 8; b++)
                        if (got.pixels[b] !== want.pixels[b])
                        begin
                            $display("%0t: pixel_%0d mismatch, expected %h, got %h",
                                     $time, b, want.pixels[b], got.pixels[b]);
                            mismatches++;
                        end
                    if (got.column !== want.column)
                    begin
                        $display("%0t: column mismatch, expected %0d, got %0d",
                                 $time, want.column, got.column);
                        mismatches++;
                    end
                    if (got.last_cell !== want.last_cell)
                    begin
                        $display("%0t: last_cell mismatch, expected %b, got %b",
                                 $time, want.last_cell, got.last_cell);
                        mismatches++;
                    end
                end
            end
            // long hold-off on request from the stimulus
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(0, 99) >= res_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        request_t it;
        int       pick;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_FG;
        cfg_data       = 16'h0000;
        req.valid      = 1'b0;
        req.action     = ACT_NONE;
        req.address    = 10'd0;
        req.write_data = 8'h00;
        req.line       = 8'h00;
        shadow_cfg = '{fg_colour: FG_RESET, bg_colour: BG_RESET,
                       top_offset: TOP_RESET, active_lines: ACTIVE_RESET};
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            char_mem[i]    = 8'h00;
            font_mem[i]    = 8'h00;
            font_loaded[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table at reset settings
        foreach (script[i])
            send_request(script[i].req, script[i].typed, script[i].pixel);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  res_stall_pct = 0;  end
                1:
                begin
                    write_registers(16'hffff, 16'h0000, 8'd0, 8'd200);
                    send_idle_pct = 61;
                    res_stall_pct = 0;
                end
                2:
                begin
                    write_registers(16'h0000, 16'hffff, 8'd239, 8'd200);
                    send_idle_pct = 0;
                    res_stall_pct = 61;
                end
                3:
                begin
                    // window taller than the text
                    write_registers(16'($urandom), 16'($urandom), 8'd0, 8'd255);
                    send_idle_pct = 31;
                    res_stall_pct = 31;
                end
                4:
                begin
                    write_registers(16'($urandom), 16'($urandom), 8'($urandom_range(0, 40)),
                                    8'($urandom_range(1, 200)));
                    send_idle_pct = 0;
                    res_stall_pct = 0;
                end
                default:
                begin
                    write_registers(16'($urandom), 16'($urandom), 8'($urandom_range(0, 239)),
                                    8'd0);
                    send_idle_pct = 31;
                    res_stall_pct = 31;
                end
            endcase

            for (int n = 0; n < PER_PHASE; n++)
            begin
                if (phase == 4 && n == 0)
                    hold_asked++;
                if (phase == 4 && n == PER_PHASE / 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    random_render();
                else if (pick < 68)
                begin
                    it.action     = ACT_CHAR_WR;
                    it.address    = ($urandom_range(0, 9) != 0) ? 10'($urandom_range(0, 999))
                                                                : 10'($urandom_range(0, 1023));
                    it.write_data = 8'($urandom_range(0, 255));
                    it.line       = 8'($urandom_range(0, 255));
                    send_request(it);
                end
                else if (pick < 94)
                begin
                    it.action     = ACT_FONT_WR;
                    it.address    = 10'($urandom_range(0, 1023));
                    it.write_data = 8'($urandom_range(0, 255));
                    it.line       = 8'($urandom_range(0, 255));
                    send_request(it);
                end
                else
                begin
                    // unused action code, ignored by the block
                    it.action     = ACT_NONE;
                    it.address    = 10'($urandom_range(0, 1023));
                    it.write_data = 8'($urandom_range(0, 255));
                    it.line       = 8'($urandom_range(0, 255));
                    send_request(it);
                end
            end
            drain_results();
        end

        repeat (4 * SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_cells.size() == 0)
            $display("text_mode_cell_renderer_top regression: pass");
        else
            $display("text_mode_cell_renderer_top regression: fail");
        $finish;
    end

endmodule
